// ===== sv/fnv1a_hash_partitioner_macros.svh =====
// assertion helpers for the hash partitioner
`ifndef FNV1A_HASH_PARTITIONER_MACROS_SVH
`define FNV1A_HASH_PARTITIONER_MACROS_SVH

// checked only out of reset
`define FHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset too
`define FHP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/fhp_pkg.sv =====
package fhp_pkg;

  localparam logic [31:0] FNV_OFFSET_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME        = 32'd16777619;
  localparam logic [15:0] PART_COUNT_RST   = 16'd1;
  localparam int unsigned DIV_STEPS        = 32;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       byte_valid;
    logic       key_end;
  } in_word_t;

  typedef struct packed {
    logic [15:0] partition_index;
    logic [31:0] hash_value;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic fold;
    logic start;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

  // xor in the byte, then multiply by the prime: 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1
  function automatic logic [31:0] fhp_fold(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// ===== sv/fhp_ctrl.sv =====
module fhp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_key_end,
  output logic            out_valid,
  input  logic            out_ready,
  output fhp_pkg::cmd_t   cmd,
  input  fhp_pkg::status_t status
);

  fhp_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fhp_pkg::ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    accept     = 1'b0;
    unique case (state_r)
      fhp_pkg::ST_RUN: begin
        in_ready  = 1'b1;
        accept    = in_valid;
        cmd.fold  = accept;
        cmd.start = accept && in_key_end;
        if (cmd.start) begin
          state_nxt = fhp_pkg::ST_DIV;
        end
      end
      fhp_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_nxt = fhp_pkg::ST_LOAD;
        end
      end
      fhp_pkg::ST_LOAD: begin
        if (!out_valid_r || out_ready) begin
          cmd.load  = 1'b1;
          state_nxt = fhp_pkg::ST_RUN;
        end
      end
      default: begin
        state_nxt = fhp_pkg::ST_RUN;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/fhp_dp.sv =====
module fhp_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  fhp_pkg::in_word_t  in_data,
  output fhp_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  fhp_pkg::cmd_t      cmd,
  output fhp_pkg::status_t   status
);

  logic [31:0] running_r, running_nxt;
  logic [31:0] quot_r, quot_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] part_cnt_r;
  fhp_pkg::out_word_t out_r, out_nxt;
  logic [31:0] folded;
  logic [16:0] rem_sh;
  logic [17:0] diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r  <= fhp_pkg::FNV_OFFSET_BASIS;
      part_cnt_r <= fhp_pkg::PART_COUNT_RST;
      cnt_r      <= '0;
    end else begin
      running_r <= running_nxt;
      cnt_r     <= cnt_nxt;
      if (cfg_we) begin
        part_cnt_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    hash_r <= hash_nxt;
    out_r  <= out_nxt;
  end

  // hash update
  always_comb begin
    folded = in_data.byte_valid ? fhp_pkg::fhp_fold(running_r, in_data.key_byte) : running_r;
    running_nxt = running_r;
    if (cmd.start) begin
      running_nxt = fhp_pkg::FNV_OFFSET_BASIS;
    end else if (cmd.fold) begin
      running_nxt = folded;
    end
  end

  // restoring divide: each step shifts in one dividend bit; only the remainder is kept
  always_comb begin
    rem_sh   = {rem_r, quot_r[31]};
    diff     = {1'b0, rem_sh} - {2'b00, part_cnt_r};
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    hash_nxt = hash_r;
    cnt_nxt  = cnt_r;
    if (cmd.start) begin
      quot_nxt = folded;
      hash_nxt = folded;
      rem_nxt  = '0;
      cnt_nxt  = '0;
    end else if (cmd.step) begin
      quot_nxt = {quot_r[30:0], 1'b0};
      rem_nxt  = diff[17] ? rem_sh[15:0] : diff[15:0];
      cnt_nxt  = cnt_r + 5'd1;
    end
  end

  assign status.div_last = (cnt_r == 5'(fhp_pkg::DIV_STEPS - 1));

  always_comb begin
    out_nxt = out_r;
    if (cmd.load) begin
      out_nxt.partition_index = (part_cnt_r == 16'd0) ? 16'd0 : rem_r;
      out_nxt.hash_value      = hash_r;
    end
  end

  assign out_data = out_r;

endmodule

// ===== sv/fnv1a_hash_partitioner.sv =====
// a key byte is folded into the running hash when accepted; an end word's result is registered after the divide
// throughput: 1 word per cycle within a key; after an end word in_ready stays low until the result is loaded
// the wait for a result and the in_ready low time both grow while an earlier result still waits in the output register
// the 32-step bit-serial modulo divider sets the end word cost
// the output register holds a result while the next key streams in
// synchronous active-low reset: running hash to offset basis, partition count to 1, no result held
module fnv1a_hash_partitioner (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fhp_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fhp_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  fhp_pkg::cmd_t    cmd;
  fhp_pkg::status_t status;

  fhp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_key_end (in_data.key_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .status     (status)
  );

  fhp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== sv/fhp_chk.sv =====
`include "fnv1a_hash_partitioner_macros.svh"

module fhp_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input fhp_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input fhp_pkg::out_word_t out_data
);

  `FHP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result dropped while stalled")
  `FHP_ASSERT(a_end_busy, in_valid && in_ready && in_data.key_end |=> !in_ready, "word taken during divide")
  `FHP_ASSERT(a_byte_ready, in_valid && in_ready && !in_data.key_end |=> in_ready, "stall inside a key")
  `FHP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result present after reset")

endmodule

bind fnv1a_hash_partitioner fhp_chk u_fhp_chk (.*);
